[design/bpfl_pkg.sv]
// ----------------------------------------------------------------------------
// bpfl_pkg
// Shared types and constants for the buffer pool free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpfl_pkg;

  // Default pool size
  localparam int NUM_BUFFERS_DEF = 16;

  // Fixed request and response field widths
  localparam int INDEX_W = 8;
  localparam int STATUS_W = 2;
  localparam int COUNT_W = 9;

  // Request kinds
  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_RELEASE = 1'b1
  } req_kind_t;

  // Response status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK = 2'd0,
    ST_EMPTY = 2'd1,
    ST_RANGE = 2'd2,
    ST_DOUBLE = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } ctrl_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch request, read link of current head
    logic commit;   // update free list, load response register
  } dp_cmd_t;

endpackage

`default_nettype wire

[design/bpfl_req_if.sv]
// ----------------------------------------------------------------------------
// bpfl_req_if
// Request channel: valid/ready handshake with allocate/release payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfl_req_if;
  logic valid;
  logic ready;
  logic req_type;
  logic [bpfl_pkg::INDEX_W-1:0] buffer_index;

  modport source (output valid, req_type, buffer_index, input ready);
  modport sink (input valid, req_type, buffer_index, output ready);
endinterface

`default_nettype wire

[design/bpfl_rsp_if.sv]
// ----------------------------------------------------------------------------
// bpfl_rsp_if
// Response channel: valid/ready handshake with allocator result payload.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpfl_rsp_if;
  logic valid;
  logic ready;
  logic [bpfl_pkg::STATUS_W-1:0] status;
  logic [bpfl_pkg::INDEX_W-1:0] granted_index;
  logic [bpfl_pkg::COUNT_W-1:0] free_count;
  logic became_available;

  modport source (output valid, status, granted_index, free_count, became_available,
                  input ready);
  modport sink (input valid, status, granted_index, free_count, became_available,
                output ready);
endinterface

`default_nettype wire

[design/buffer_pool_free_list_allocator.sv]
// ----------------------------------------------------------------------------
// buffer_pool_free_list_allocator
// Hands out and takes back fixed buffers from a LIFO free list, with
// double-release and range checks.
//
//   Channel  Dir  Payload                                          Handshake
//   req      in   req_type, buffer_index                           valid/ready
//   rsp      out  status, granted_index, free_count, became_avail. valid/ready
//
// Capture latches a request and reads the head's link from the link memory
// (registered read port); commit then updates the list and loads the
// response register. One request is in flight at a time; a new request is
// accepted while the previous result waits in the response register. A stall
// on rsp holds the pending request in execute. Reset (synchronous) restores
// the full list in index order at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module buffer_pool_free_list_allocator #(
  parameter int NUM_BUFFERS = bpfl_pkg::NUM_BUFFERS_DEF
) (
  input wire logic  clk,
  input wire logic  rst,
  bpfl_req_if.sink  req,
  bpfl_rsp_if.source rsp
);

  bpfl_pkg::dp_cmd_t cmd;

  // Sequencer
  bpfl_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .out_valid (rsp.valid),
    .out_ready (rsp.ready),
    .cmd       (cmd)
  );

  // Free list datapath
  bpfl_dp #(
    .NUM_BUFFERS (NUM_BUFFERS)
  ) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .req_type         (req.req_type),
    .buffer_index     (req.buffer_index),
    .status           (rsp.status),
    .granted_index    (rsp.granted_index),
    .free_count       (rsp.free_count),
    .became_available (rsp.became_available)
  );

endmodule

`default_nettype wire

[design/bpfl_ctrl.sv]
// ----------------------------------------------------------------------------
// bpfl_ctrl
// Sequencer: accepts one request, executes it, and tracks the response
// register's valid flag.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfl_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output bpfl_pkg::dp_cmd_t     cmd
);

  bpfl_pkg::ctrl_state_t state, state_next;
  logic out_valid_next;
  logic slot_free;

  // Response register can take a result this cycle
  assign slot_free = !out_valid || out_ready;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      bpfl_pkg::S_IDLE: if (in_valid) state_next = bpfl_pkg::S_EXEC;
      bpfl_pkg::S_EXEC: if (slot_free) state_next = bpfl_pkg::S_IDLE;
      default: state_next = bpfl_pkg::S_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready = 1'b0;
    cmd = '0;
    unique case (state)
      bpfl_pkg::S_IDLE: begin
        in_ready = 1'b1;
        cmd.capture = in_valid;
      end
      bpfl_pkg::S_EXEC: begin
        cmd.commit = slot_free;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  // Set on commit, drop when taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.commit) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bpfl_pkg::S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // Accepted request moves to execute
  a_accept_exec: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == bpfl_pkg::S_EXEC))
    else $error("accepted request did not enter execute");

  // Commit always presents a result
  a_commit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> out_valid)
    else $error("commit did not raise response valid");

  // Never overwrite an untaken result
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!out_valid || out_ready))
    else $error("commit while response register full");

endmodule

`default_nettype wire

[design/bpfl_dp.sv]
// ----------------------------------------------------------------------------
// bpfl_dp
// Datapath: link memory, free-mark bitmap, list head, free count and the
// response register.
// ----------------------------------------------------------------------------
`default_nettype none

module bpfl_dp #(
  parameter int NUM_BUFFERS = bpfl_pkg::NUM_BUFFERS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire bpfl_pkg::dp_cmd_t               cmd,
  input  wire logic                            req_type,
  input  wire logic [bpfl_pkg::INDEX_W-1:0]    buffer_index,
  output logic [bpfl_pkg::STATUS_W-1:0]        status,
  output logic [bpfl_pkg::INDEX_W-1:0]         granted_index,
  output logic [bpfl_pkg::COUNT_W-1:0]         free_count,
  output logic                                 became_available
);

  localparam int IDX_W = $clog2(NUM_BUFFERS);
  localparam int LINK_W = $clog2(NUM_BUFFERS + 1);
  localparam logic [LINK_W-1:0] NULL_LINK = LINK_W'(NUM_BUFFERS);
  localparam logic [bpfl_pkg::INDEX_W:0] POOL_END = (bpfl_pkg::INDEX_W + 1)'(NUM_BUFFERS);

  // Free list state
  logic [LINK_W-1:0] link_mem [NUM_BUFFERS];
  logic [NUM_BUFFERS-1:0] link_written;
  logic [NUM_BUFFERS-1:0] free_mark;
  logic [LINK_W-1:0] list_head;
  logic [LINK_W-1:0] free_total;

  // Latched request and head link read
  logic req_type_q;
  logic [bpfl_pkg::INDEX_W-1:0] buffer_index_q;
  logic [LINK_W-1:0] rd_link;
  logic rd_written;

  logic head_valid;
  logic [IDX_W-1:0] head_idx;
  logic [LINK_W-1:0] head_link;
  logic pool_empty;
  logic in_range;
  logic [IDX_W-1:0] rel_idx;
  logic rel_free;
  logic do_alloc, do_release;
  logic wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [LINK_W-1:0] wr_data;
  bpfl_pkg::status_t status_next;

  // Decode head and request
  assign head_valid = (list_head < NULL_LINK);
  assign head_idx = head_valid ? list_head[IDX_W-1:0] : '0;
  assign head_link = rd_written ? rd_link : (LINK_W'(head_idx) + LINK_W'(1));
  assign pool_empty = (free_total == '0) || !head_valid;
  assign in_range = ({1'b0, buffer_index_q} < POOL_END);
  assign rel_idx = in_range ? buffer_index_q[IDX_W-1:0] : '0;
  assign rel_free = free_mark[rel_idx];

  always_comb begin
    do_alloc = 1'b0;
    do_release = 1'b0;
    status_next = bpfl_pkg::ST_OK;
    if (req_type_q == bpfl_pkg::REQ_ALLOC) begin
      if (pool_empty) status_next = bpfl_pkg::ST_EMPTY;
      else do_alloc = cmd.commit;
    end else begin
      if (!in_range) status_next = bpfl_pkg::ST_RANGE;
      else if (rel_free) status_next = bpfl_pkg::ST_DOUBLE;
      else do_release = cmd.commit;
    end
  end

  // Single write port: pop nulls the head's link, push links to old head
  assign wr_en = do_alloc || do_release;
  assign wr_addr = do_alloc ? head_idx : rel_idx;
  assign wr_data = do_alloc ? NULL_LINK : list_head;

  always_ff @(posedge clk) begin
    if (wr_en) link_mem[wr_addr] <= wr_data;
    if (cmd.capture) rd_link <= link_mem[head_idx];
  end

  // Latch request and the written flag of the head entry
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_type_q <= req_type;
      buffer_index_q <= buffer_index;
      rd_written <= link_written[head_idx];
    end
  end

  // Update list state
  always_ff @(posedge clk) begin
    if (rst) begin
      link_written <= '0;
      free_mark <= '1;
      list_head <= '0;
      free_total <= NULL_LINK;
    end else begin
      if (wr_en) link_written[wr_addr] <= 1'b1;
      if (do_alloc) begin
        free_mark[head_idx] <= 1'b0;
        list_head <= head_link;
        free_total <= free_total - LINK_W'(1);
      end else if (do_release) begin
        free_mark[rel_idx] <= 1'b1;
        list_head <= LINK_W'(rel_idx);
        free_total <= free_total + LINK_W'(1);
      end
    end
  end

  // Load response register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      status <= status_next;
      granted_index <= do_alloc ? bpfl_pkg::INDEX_W'(head_idx) : '0;
      became_available <= do_release && (free_total == '0);
      if (do_alloc) free_count <= bpfl_pkg::COUNT_W'(free_total - LINK_W'(1));
      else if (do_release) free_count <= bpfl_pkg::COUNT_W'(free_total + LINK_W'(1));
      else free_count <= bpfl_pkg::COUNT_W'(free_total);
    end
  end

  // Count matches bitmap
  a_count_marks: assert property (@(posedge clk) disable iff (rst)
    $countones(free_mark) == int'(free_total))
    else $error("free count disagrees with free marks");

  // Head is null exactly when the pool is empty
  a_head_null: assert property (@(posedge clk) disable iff (rst)
    (free_total == '0) == (list_head == NULL_LINK))
    else $error("list head and free count disagree");

  // Head entry is always free
  a_head_free: assert property (@(posedge clk) disable iff (rst)
    head_valid |-> free_mark[head_idx])
    else $error("list head points at an allocated buffer");

endmodule

`default_nettype wire
